// ----- hw/rtl/rup_frame_reassembler_core_defines.svh -----
// Assertion macros for the frame reassembler RTL.
`ifndef RUP_FRAME_REASSEMBLER_CORE_DEFINES_SVH
`define RUP_FRAME_REASSEMBLER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define RUP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("%m: check failed");
`define RUP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("%m: check failed");
`else
`define RUP_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define RUP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- hw/rtl/rup_pkg.sv -----
package rup_pkg;
	localparam int MaxFramesDefault = 64;
	localparam int InWidth = 216;
	localparam int OutWidth = 112;
	localparam logic [15:0] ProtoVersion = 16'd5;

	typedef enum logic [2:0] {
		ST_STORED   = 3'd0,
		ST_BAD_VER  = 3'd1,
		ST_BAD_ID   = 3'd2,
		ST_BAD_CNT  = 3'd3,
		ST_BAD_IDX  = 3'd4,
		ST_DISABLED = 3'd5,
		ST_TIMEOUT  = 3'd6,
		ST_IDLE     = 3'd7
	} status_t;

	typedef enum logic [1:0] {
		REG_DATA_ID = 2'd0,
		REG_ENABLE  = 2'd1,
		REG_TIMEOUT = 2'd2
	} reg_idx_t;

	// Request from the control sequencer to the slot memory.
	typedef struct packed {
		logic        wr;
		logic        rd;
		logic [7:0]  addr;
		logic [15:0] wdata;
	} slot_req_t;

	function automatic logic format_bad(input logic [31:0] d, input logic [39:0] c);
		logic [15:0] year;
		logic [7:0] month, day, hour, minute, second;
		logic [15:0] ms;
		begin
			year = d[31:16];
			month = d[15:8];
			day = d[7:0];
			hour = c[39:32];
			minute = c[31:24];
			second = c[23:16];
			ms = c[15:0];
			format_bad = (year < 16'd2000) || (year > 16'd2500) || (month < 8'd1) ||
				(month > 8'd12) || (day < 8'd1) || (day > 8'd31) || (hour > 8'd23) ||
				(minute > 8'd59) || (second > 8'd59) || (ms > 16'd999);
		end
	endfunction
endpackage

// ----- hw/rtl/rup_frame_reassembler_core.sv -----
// Frame reassembler core. Each input request is either a frame header or a
// timeout poll and yields exactly one result request. A poll, a rejected
// frame or a frame with processing disabled passes through the CHECK and OUT
// states before its result is presented. A stored frame writes its slot, then
// scans slots 0 to frame_count-1 through the single read port of the slot
// sequence memory, one slot per cycle, in the SCAN0 and SCAN states, and then
// passes through FINISH and OUT. The scan stops early at the first mismatch or
// unwritten slot. One request is worked on at a time, and the next request is
// only accepted in the cycle after the previous result has been taken. Slot
// valid bits are flip-flops cleared by reset, so no clearing pass is needed.
`include "rup_frame_reassembler_core_defines.svh"
module rup_frame_reassembler_core
	import rup_pkg::*;
#(
	parameter int MAX_FRAMES = MaxFramesDefault
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_axis_tvalid,
	output logic                s_axis_tready,
	// tdata: arrival_time[46:0], protocol_version, data_id, frame_count,
	// frame_index, sequence_number, plant_date, plant_clock, zero pad
	input  logic [InWidth-1:0]  s_axis_tdata,
	// tuser: operation[0], sim_frame[1]
	input  logic [1:0]          s_axis_tuser,
	output logic                m_axis_tvalid,
	input  logic                m_axis_tready,
	// tdata: status[2:0], frame_stored, store_slot[5:0], packet_ready,
	// packet_number, packet_sim, packet_server_time[46:0], time_format_error,
	// time_duplicate, time_backwards, lost_packets[31:0], receiving, zero pad
	output logic [OutWidth-1:0] m_axis_tdata,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);
	localparam int CW = $clog2(MAX_FRAMES + 1);

	typedef enum logic [2:0] {
		S_IDLE, S_CHECK, S_SCAN0, S_SCAN, S_FINISH, S_OUT
	} state_t;

	state_t state_q;
	logic [31:0] data_id_q;
	logic enable_q;
	logic [15:0] timeout_q;

	logic receiving_q, first_q, sim_acc_q;
	logic [46:0] last_arr_q, zero_time_q;
	logic [15:0] exp_seq_q;
	logic [31:0] lost_q;
	logic [31:0] prev_date_q, zero_date_q;
	logic [39:0] prev_clock_q, zero_clock_q;

	// Latched request.
	logic op_q, sim_q;
	logic [46:0] t_q;
	logic [15:0] ver_q, cnt_q, idx_q, seq_q;
	logic [31:0] did_q, pdate_q;
	logic [39:0] pclock_q;

	logic [CW-1:0] scan_q;
	logic [15:0] ref_seq_q;
	logic ready_q;

	// Result fields.
	logic [2:0] o_status_q;
	logic o_stored_q, o_pready_q, o_psim_q, o_fmt_q, o_dup_q, o_back_q;
	logic [5:0] o_slot_q;
	logic [15:0] o_pnum_q;
	logic [46:0] o_ptime_q;
	logic out_valid_q;

	slot_req_t req;
	logic [15:0] rdata;
	logic rvalid;

	rup_slot_mem #(.MaxFrames(MAX_FRAMES)) u_mem (
		.clk(clk), .arst_n(arst_n), .req(req), .clr_valid(1'b0),
		.rdata(rdata), .rvalid(rvalid)
	);

	logic [46:0] diff;
	assign diff = t_q - last_arr_q;

	// The latched frame header passes every check in turn.
	logic frame_ok;
	assign frame_ok = enable_q && ver_q == ProtoVersion && did_q == data_id_q &&
		cnt_q <= 16'(MAX_FRAMES) && idx_q < cnt_q;

	assign s_axis_tready = (state_q == S_IDLE) && !out_valid_q;
	assign cfg_ready = (state_q == S_IDLE) && !out_valid_q;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {{(OutWidth-111){1'b0}}, receiving_q, lost_q, o_back_q, o_dup_q,
		o_fmt_q, o_ptime_q, o_psim_q, o_pnum_q, o_pready_q, o_slot_q, o_stored_q, o_status_q};

	// Memory request: write in CHECK for a passing frame, read during scan.
	always_comb begin
		req = '0;
		if (state_q == S_CHECK && op_q == 1'b0 && frame_ok) begin
			req.wr = 1'b1;
			req.addr = idx_q[7:0];
			req.wdata = seq_q;
		end else if (state_q == S_SCAN0 || state_q == S_SCAN) begin
			req.rd = 1'b1;
			req.addr = 8'(scan_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			data_id_q <= '0;
			enable_q <= 1'b1;
			timeout_q <= 16'd1000;
			receiving_q <= 1'b0;
			first_q <= 1'b1;
			sim_acc_q <= 1'b0;
			last_arr_q <= '0;
			zero_time_q <= '0;
			exp_seq_q <= '0;
			lost_q <= '0;
			prev_date_q <= '0;
			prev_clock_q <= '0;
			zero_date_q <= '0;
			zero_clock_q <= '0;
			out_valid_q <= 1'b0;
			scan_q <= '0;
			ready_q <= 1'b0;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DATA_ID: data_id_q <= cfg_data;
					REG_ENABLE:  enable_q <= cfg_data[0];
					REG_TIMEOUT: timeout_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						op_q <= s_axis_tuser[0];
						sim_q <= s_axis_tuser[1];
						t_q <= s_axis_tdata[46:0];
						ver_q <= s_axis_tdata[62:47];
						did_q <= s_axis_tdata[94:63];
						cnt_q <= s_axis_tdata[110:95];
						idx_q <= s_axis_tdata[126:111];
						seq_q <= s_axis_tdata[142:127];
						pdate_q <= s_axis_tdata[174:143];
						pclock_q <= s_axis_tdata[214:175];
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					o_pready_q <= 1'b0;
					o_pnum_q <= '0;
					o_psim_q <= 1'b0;
					o_ptime_q <= '0;
					o_fmt_q <= 1'b0;
					o_dup_q <= 1'b0;
					o_back_q <= 1'b0;
					if (op_q) begin
						o_stored_q <= 1'b0;
						o_slot_q <= '0;
						state_q <= S_OUT;
						if (receiving_q && t_q >= last_arr_q && diff > 47'(timeout_q)) begin
							receiving_q <= 1'b0;
							first_q <= 1'b1;
							o_status_q <= ST_TIMEOUT;
						end else begin
							o_status_q <= ST_IDLE;
						end
					end else begin
						last_arr_q <= t_q;
						if (!receiving_q) begin
							lost_q <= '0;
						end
						receiving_q <= 1'b1;
						if (!frame_ok) begin
							o_stored_q <= 1'b0;
							o_slot_q <= '0;
							state_q <= S_OUT;
							if (!enable_q) o_status_q <= ST_DISABLED;
							else if (ver_q != ProtoVersion) o_status_q <= ST_BAD_VER;
							else if (did_q != data_id_q) o_status_q <= ST_BAD_ID;
							else if (cnt_q > 16'(MAX_FRAMES)) o_status_q <= ST_BAD_CNT;
							else o_status_q <= ST_BAD_IDX;
						end else begin
							o_status_q <= ST_STORED;
							o_stored_q <= 1'b1;
							o_slot_q <= idx_q[5:0];
							if (idx_q == 16'd0) begin
								zero_time_q <= t_q;
								sim_acc_q <= sim_q;
								zero_date_q <= pdate_q;
								zero_clock_q <= pclock_q;
							end else begin
								sim_acc_q <= sim_acc_q | sim_q;
							end
							scan_q <= '0;
							ready_q <= 1'b1;
							state_q <= S_SCAN0;
						end
					end
				end
				S_SCAN0: begin
					// Read of slot 0 issued; move to the next slot.
					scan_q <= scan_q + CW'(1);
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					// rdata holds slot scan_q-1.
					if (scan_q == CW'(1)) begin
						ref_seq_q <= rdata;
						if (!rvalid) ready_q <= 1'b0;
					end else if (!rvalid || rdata != ref_seq_q) begin
						ready_q <= 1'b0;
					end
					if (32'(scan_q) >= 32'(cnt_q) ||
						(scan_q != CW'(1) && (!rvalid || rdata != ref_seq_q)) ||
						(scan_q == CW'(1) && !rvalid)) begin
						state_q <= S_FINISH;
					end else begin
						scan_q <= scan_q + CW'(1);
					end
				end
				S_FINISH: begin
					state_q <= S_OUT;
					if (ready_q) begin
						o_pready_q <= 1'b1;
						o_pnum_q <= ref_seq_q;
						o_psim_q <= sim_acc_q;
						o_ptime_q <= zero_time_q;
						o_fmt_q <= format_bad(zero_date_q, zero_clock_q);
						o_dup_q <= (zero_date_q == prev_date_q) && (zero_clock_q == prev_clock_q);
						o_back_q <= (prev_date_q > zero_date_q) ||
							((prev_date_q == zero_date_q) && (prev_clock_q > zero_clock_q));
						prev_date_q <= zero_date_q;
						prev_clock_q <= zero_clock_q;
						if (first_q) begin
							first_q <= 1'b0;
						end else if (ref_seq_q != exp_seq_q) begin
							if ({1'b0, lost_q} + {17'd0, ref_seq_q - exp_seq_q} > 33'hFFFFFFFF)
								lost_q <= 32'hFFFFFFFF;
							else
								lost_q <= lost_q + {16'd0, ref_seq_q - exp_seq_q};
						end
						exp_seq_q <= ref_seq_q + 16'd1;
					end
				end
				S_OUT: begin
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`RUP_ASSERT_IMPL(a_no_accept_busy, clk, arst_n, state_q != S_IDLE, !s_axis_tready)
	`RUP_ASSERT_NEXT(a_out_after, clk, arst_n, state_q == S_OUT, out_valid_q)
	`RUP_ASSERT_IMPL(a_ready_stored, clk, arst_n, out_valid_q && o_pready_q, o_stored_q)
endmodule

// ----- hw/rtl/rup_slot_mem.sv -----
module rup_slot_mem
	import rup_pkg::*;
#(
	parameter int MaxFrames = MaxFramesDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  slot_req_t       req,
	input  logic            clr_valid,
	output logic [15:0]     rdata,
	output logic            rvalid
);
	localparam int AW = (MaxFrames > 1) ? $clog2(MaxFrames) : 1;

	logic [15:0] mem [MaxFrames];
	logic [MaxFrames-1:0] valid_q;
	logic [AW-1:0] a;

	assign a = req.addr[AW-1:0];

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[a] <= req.wdata;
		end
		if (req.rd) begin
			rdata <= mem[a];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rvalid <= 1'b0;
		end else begin
			if (clr_valid) begin
				valid_q <= '0;
			end else if (req.wr) begin
				valid_q[a] <= 1'b1;
			end
			if (req.rd) begin
				rvalid <= valid_q[a];
			end
		end
	end
endmodule
